### hdl/byte_set_statistics_assert.svh
// Assertion macros for the byte set statistics block.
`ifndef BYTE_SET_STATISTICS_ASSERT_SVH
`define BYTE_SET_STATISTICS_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/bss_pkg.sv
// Types and constants shared by the byte set statistics modules.
package bss_pkg;

  localparam int SAMPLE_W = 8;
  localparam int MEAN_W   = 16;
  localparam int MED_W    = 9;
  localparam int ICNT_W   = 7;
  localparam int OUT_W    = 48;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SRCH_INIT,
    ST_SCAN,
    ST_STEP,
    ST_DIV_INIT,
    ST_DIV,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic accept;
    logic srch_init;
    logic scan;
    logic step;
    logic div_start;
    logic div_step;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic pass_done;
    logic bit_zero;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

### hdl/byte_set_statistics.sv
// Byte set statistics: top level, min/max/mean/median of a set of bytes.
//
// Input: one byte per beat on s_tdata[7:0], s_tlast marks the final byte.
// While loading, s_tready is high and one byte is taken each cycle. Bytes
// beyond MAX_COUNT are dropped and flag the result as overflowed.
// After the last beat s_tready drops. The median is found by an 8-pass
// bitwise search over the sample memory (one read port, each pass a full
// scan of the set), then a restoring divider forms the mean, one quotient
// bit per cycle. Loading runs at one byte per cycle; the next set is not
// taken until the last one's result has gone into the output register.
// Output: one beat per set on m_tdata, held in an output register. A stalled
// m_tready does not block loading of the next set; only a second finished
// result waits until the first is taken.
// Reset (rst, synchronous) empties the set and drops any pending result.
module byte_set_statistics
  import bss_pkg::*;
#(
  parameter int MAX_COUNT = 64
)
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,  // [7:0] sample
  input  logic             s_tlast,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,  // minimum, maximum, mean_q8, median_halves, item_count
  output logic             m_tuser   // overflow
);

  localparam logic [ICNT_W-1:0] FULL_COUNT = ICNT_W'(MAX_COUNT);

  cmd_t                cmd;
  status_t             status;
  logic [SAMPLE_W-1:0] out_min, out_max;
  logic [MEAN_W-1:0]   out_mean;
  logic [MED_W-1:0]    out_median;
  logic [ICNT_W-1:0]   out_count;
  logic                out_ovf;
  logic                last_beat;

  bss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bss_datapath #(
    .MAX_COUNT (MAX_COUNT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .sample     (s_tdata),
    .m_tready   (m_tready),
    .out_valid  (m_tvalid),
    .out_min    (out_min),
    .out_max    (out_max),
    .out_mean   (out_mean),
    .out_median (out_median),
    .out_count  (out_count),
    .out_ovf    (out_ovf)
  );

  assign m_tdata   = {out_count, out_median, out_mean, out_max, out_min};
  assign m_tuser   = out_ovf;
  assign last_beat = s_tvalid && s_tready && s_tlast;

`include "byte_set_statistics_assert.svh"

  `BSS_ASSERT_NEXT(a_last_stalls_input, last_beat, !s_tready, "input taken after last beat")
  `BSS_ASSERT_NOW(a_capture_free, cmd.capture, status.out_free, "result overwrote a pending beat")
  `BSS_ASSERT_NOW(a_min_le_max, m_tvalid, out_min <= out_max, "minimum above maximum")
  `BSS_ASSERT_NOW(a_ovf_full, m_tvalid && m_tuser, out_count == FULL_COUNT, "ovf on short set")

endmodule

### hdl/bss_ctrl.sv
// Sequencer for loading, median search, mean division and result hand-off.
module bss_ctrl
  import bss_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  input  logic    s_tlast,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_LOAD: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid && s_tlast) begin
          state_next = ST_SRCH_INIT;
        end
      end
      ST_SRCH_INIT: begin
        cmd.srch_init = 1'b1;
        state_next    = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.pass_done) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd.step = 1'b1;
        if (status.bit_zero) begin
          state_next = ST_DIV_INIT;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_DIV_INIT: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        // hold here until the output register can take the beat
        if (status.out_free) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

### hdl/bss_datapath.sv
// Sample store, running stats, bitwise median search, mean divider, output register.
module bss_datapath
  import bss_pkg::*;
#(
  parameter int MAX_COUNT = 64
)
(
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output status_t             status,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                m_tready,
  output logic                out_valid,
  output logic [SAMPLE_W-1:0] out_min,
  output logic [SAMPLE_W-1:0] out_max,
  output logic [MEAN_W-1:0]   out_mean,
  output logic [MED_W-1:0]    out_median,
  output logic [ICNT_W-1:0]   out_count,
  output logic                out_ovf
);

  localparam int CW  = $clog2(MAX_COUNT + 1);
  localparam int AW  = $clog2(MAX_COUNT);
  localparam int SW  = SAMPLE_W + CW;
  localparam int DW  = SW + 8;
  localparam int DCW = $clog2(DW + 1);
  localparam logic [CW-1:0]  FULL   = CW'(MAX_COUNT);
  localparam logic [DCW-1:0] DSTEPS = DCW'(DW);

  logic [SAMPLE_W-1:0] mem [MAX_COUNT];
  logic [SAMPLE_W-1:0] rd_data;
  logic [AW-1:0]       rd_addr;

  logic [CW-1:0]       count;
  logic [SW-1:0]       running_sum;
  logic [SAMPLE_W-1:0] running_min;
  logic [SAMPLE_W-1:0] running_max;
  logic                dropped;

  // median search: two order statistics found bit by bit in one shared scan
  logic [CW-1:0]       idx;
  logic                rd_vld;
  logic [2:0]          bitpos;
  logic [SAMPLE_W-1:0] p_lo, p_hi;
  logic [CW-1:0]       cnt_lo, cnt_hi;
  logic [CW-1:0]       k_lo, k_hi;
  logic [SAMPLE_W-1:0] mask, set_bit, t_lo, t_hi;

  // restoring divider for sum*256/count
  logic [DW-1:0]       dvd;
  logic [CW-1:0]       rem;
  logic [DCW-1:0]      div_cnt;
  logic [CW:0]         rem_sh, diff;

  logic                full;

  assign full    = (count == FULL);
  assign rd_addr = idx[AW-1:0];
  assign k_hi    = count >> 1;
  assign k_lo    = count[0] ? k_hi : k_hi - CW'(1);
  assign mask    = 8'h7f >> (3'd7 - bitpos);
  assign set_bit = 8'h01 << bitpos;
  assign t_lo    = p_lo | mask;
  assign t_hi    = p_hi | mask;
  assign rem_sh  = {rem, dvd[DW-1]};
  assign diff    = rem_sh - {1'b0, count};

  always_ff @(posedge clk) begin
    if (cmd.accept && !full) begin
      mem[count[AW-1:0]] <= sample;
    end
    rd_data <= mem[rd_addr];
  end

  // running statistics of the current set
  always_ff @(posedge clk) begin
    if (rst || cmd.capture) begin
      count       <= '0;
      running_sum <= '0;
      running_min <= '0;
      running_max <= '0;
      dropped     <= 1'b0;
    end else if (cmd.accept) begin
      if (full) begin
        dropped <= 1'b1;
      end else begin
        count       <= count + CW'(1);
        running_sum <= running_sum + SW'(sample);
        if (count == '0) begin
          running_min <= sample;
          running_max <= sample;
        end else begin
          if (sample < running_min) running_min <= sample;
          if (sample > running_max) running_max <= sample;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      rd_vld <= 1'b0;
      bitpos <= 3'd7;
      cnt_lo <= '0;
      cnt_hi <= '0;
    end else if (cmd.srch_init) begin
      idx    <= '0;
      rd_vld <= 1'b0;
      bitpos <= 3'd7;
      cnt_lo <= '0;
      cnt_hi <= '0;
      p_lo   <= '0;
      p_hi   <= '0;
    end else if (cmd.scan) begin
      if (idx < count) begin
        idx    <= idx + CW'(1);
        rd_vld <= 1'b1;
      end else begin
        rd_vld <= 1'b0;
      end
      if (rd_vld) begin
        if (rd_data <= t_lo) cnt_lo <= cnt_lo + CW'(1);
        if (rd_data <= t_hi) cnt_hi <= cnt_hi + CW'(1);
      end
    end else if (cmd.step) begin
      // answer lies above the trial value when too few samples are at or below it
      if (!(cnt_lo > k_lo)) p_lo <= p_lo | set_bit;
      if (!(cnt_hi > k_hi)) p_hi <= p_hi | set_bit;
      bitpos <= bitpos - 3'd1;
      idx    <= '0;
      rd_vld <= 1'b0;
      cnt_lo <= '0;
      cnt_hi <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      div_cnt <= DSTEPS;
      dvd     <= {running_sum, 8'h00};
      rem     <= '0;
    end else if (cmd.div_step && div_cnt != '0) begin
      div_cnt <= div_cnt - DCW'(1);
      if (!diff[CW]) begin
        rem <= diff[CW-1:0];
        dvd <= {dvd[DW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[CW-1:0];
        dvd <= {dvd[DW-2:0], 1'b0};
      end
    end
  end

  // output register: the next set loads while a result waits here
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.capture) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      out_min    <= running_min;
      out_max    <= running_max;
      out_mean   <= dvd[MEAN_W-1:0];
      out_median <= {1'b0, p_lo} + {1'b0, p_hi};
      out_count  <= ICNT_W'(count);
      out_ovf    <= dropped;
    end
  end

  assign status.pass_done = (idx == count) && !rd_vld;
  assign status.bit_zero  = (bitpos == 3'd0);
  assign status.div_done  = (div_cnt == '0);
  assign status.out_free  = !out_valid || m_tready;

endmodule
